@@ src/pres_pkg.sv @@
// Package for the PRESENT-80 block cipher: FSM states, register and function codes,
// S-box layers, bit permutations and the key-schedule step.
// No dependencies; imported by present80_block_cipher.
package pres_pkg;

  localparam int unsigned NumKeys   = 32;
  localparam int unsigned KeyIdxW   = $clog2(NumKeys);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned BlockW    = 64;
  localparam int unsigned KeyLowW   = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;

  // Operation carried in tuser
  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_DEC
  } pres_state_e;

  typedef logic [BlockW-1:0]  blk_t;
  typedef logic [KeyLowW-1:0] klo_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;  4'h1: y = 4'h5;  4'h2: y = 4'h6;  4'h3: y = 4'hB;
      4'h4: y = 4'h9;  4'h5: y = 4'h0;  4'h6: y = 4'hA;  4'h7: y = 4'hD;
      4'h8: y = 4'h3;  4'h9: y = 4'hE;  4'hA: y = 4'hF;  4'hB: y = 4'h8;
      4'hC: y = 4'h4;  4'hD: y = 4'h7;  4'hE: y = 4'h1;  default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'h5;  4'h1: y = 4'hE;  4'h2: y = 4'hF;  4'h3: y = 4'h8;
      4'h4: y = 4'hC;  4'h5: y = 4'h1;  4'h6: y = 4'h2;  4'h7: y = 4'hD;
      4'h8: y = 4'hB;  4'h9: y = 4'h4;  4'hA: y = 4'h6;  4'hB: y = 4'h3;
      4'hC: y = 4'h0;  4'hD: y = 4'h7;  4'hE: y = 4'h9;  default: y = 4'hA;
    endcase
    return y;
  endfunction

  function automatic blk_t sub_fwd(input blk_t v);
    blk_t acc;
    for (int n = 0; n < BlockW / 4; n++) begin
      acc[n*4 +: 4] = sbox_fwd(v[n*4 +: 4]);
    end
    return acc;
  endfunction

  function automatic blk_t sub_inv(input blk_t v);
    blk_t acc;
    for (int n = 0; n < BlockW / 4; n++) begin
      acc[n*4 +: 4] = sbox_inv(v[n*4 +: 4]);
    end
    return acc;
  endfunction

  // Move bit b to (b*16) mod 63; the top bit stays put. Multiplying by 16
  // modulo 63 rotates the 6-bit index left by four places.
  function automatic blk_t perm_fwd(input blk_t v);
    blk_t       acc;
    logic [5:0] bi;
    acc[BlockW-1] = v[BlockW-1];
    for (int b = 0; b < BlockW - 1; b++) begin
      bi = 6'(b);
      acc[{bi[1:0], bi[5:2]}] = v[b];
    end
    return acc;
  endfunction

  // Inverse: move bit b to (b*4) mod 63, a rotate left by two places.
  function automatic blk_t perm_inv(input blk_t v);
    blk_t       acc;
    logic [5:0] bi;
    acc[BlockW-1] = v[BlockW-1];
    for (int b = 0; b < BlockW - 1; b++) begin
      bi = 6'(b);
      acc[{bi[3:0], bi[5:4]}] = v[b];
    end
    return acc;
  endfunction

  // One key-schedule step on the 80-bit key {hi, lo}: rotate left by 61,
  // substitute the top nibble, XOR the round counter into bits 19..15.
  function automatic logic [BlockW+KeyLowW-1:0] sched_step(input blk_t hi, input klo_t lo,
                                                          input logic [KeyIdxW-1:0] rnd);
    logic [BlockW+KeyLowW-1:0] k;
    logic [BlockW+KeyLowW-1:0] rot;
    k   = {hi, lo};
    rot = {k[18:0], k[BlockW+KeyLowW-1:19]};
    rot[BlockW+KeyLowW-1 -: 4] = sbox_fwd(rot[BlockW+KeyLowW-1 -: 4]);
    rot[KeyLowW+3:KeyLowW-1]   = rot[KeyLowW+3:KeyLowW-1] ^ rnd;
    return rot;
  endfunction

endpackage

@@ src/present80_block_cipher.sv @@
// PRESENT-80 block cipher top level: stream ports, key registers, round-key store
// and the round sequencer. Depends on pres_pkg.
//
// Each item on the slave stream is one 64-bit block; tuser selects encrypt (0) or
// decrypt (1). One round unit is reused once per cycle under a small sequencer, so
// an item occupies the block from its acceptance until its result: encrypt runs 31
// rounds and a whitening step, decrypt runs the whitening XOR and 31 inverse
// rounds. The run length is set by the single round unit and the one read port of the
// round-key store. The slave side is ready only while no item is in work and no
// result waits on the master side, so a new item is taken only after the result of
// the last one has been handed over and the sequencer is idle again; the block
// never holds two items at once. Encrypt takes the key from the two
// configuration registers (index 0: key bits 79..16, index 1: key bits 15..0) and
// stores its 32 round keys; decrypt uses the keys stored by the latest encryption,
// and reads as all zero if no encryption has completed since reset (a valid bit
// per entry, cleared at reset). Write the key only while the block is idle;
// writes to other indexes are accepted and dropped. The configuration port is
// always ready.
module present80_block_cipher
  import pres_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BlockW-1:0]  s_axis_tdata,   // [63:0] block
  input  logic               s_axis_tuser,   // [0] func
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [BlockW-1:0]  m_axis_tdata,   // [63:0] result_block
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [BlockW-1:0]  cfg_data_i
);

  pres_state_e        state_q, state_d;
  logic [KeyIdxW-1:0] idx_q, idx_d;
  blk_t               blk_q, blk_d;
  blk_t               khi_q, khi_d;
  klo_t               klo_q, klo_d;
  blk_t               res_q, res_d;
  logic               ovld_q, ovld_d;
  blk_t               key_high_q;
  klo_t               key_low_q;

  // Round-key store with a valid bit per entry
  blk_t               mem [NumKeys];
  logic [NumKeys-1:0] vld_q;
  logic               mem_we;
  logic [KeyIdxW-1:0] rd_addr;
  blk_t               rd_key_q;
  logic               rd_vld_q;
  blk_t               rd_key;

  blk_t               dec_t;
  blk_t               dec_n;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE) && !ovld_q;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = res_q;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_KEY_HIGH) begin
        key_high_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_KEY_LOW) begin
        key_low_q <= cfg_data_i[KeyLowW-1:0];
      end
    end
  end

  // Store: write the current round key during encrypt, read one ahead during decrypt
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= khi_q;
    end
    rd_key_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[idx_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // An entry never written since reset reads as zero
  assign rd_key = rd_vld_q ? rd_key_q : '0;

  // Decrypt round: the first cycle is the whitening XOR alone
  assign dec_t = (idx_q == KeyIdxW'(NumKeys - 1)) ? blk_q : sub_inv(perm_inv(blk_q));
  assign dec_n = dec_t ^ rd_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    khi_q <= khi_d;
    klo_q <= klo_d;
    res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    blk_d   = blk_q;
    khi_d   = khi_q;
    klo_d   = klo_q;
    res_d   = res_q;
    ovld_d  = ovld_q && !m_axis_tready;
    mem_we  = 1'b0;
    rd_addr = KeyIdxW'(NumKeys - 1);
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          blk_d = s_axis_tdata;
          khi_d = key_high_q;
          klo_d = key_low_q;
          if (s_axis_tuser == FUNC_DEC) begin
            idx_d   = KeyIdxW'(NumKeys - 1);
            state_d = ST_DEC;
          end else begin
            idx_d   = '0;
            state_d = ST_ENC;
          end
        end
      end
      ST_ENC: begin
        // Store round key idx, then advance a round or, at the last key, finish
        mem_we = 1'b1;
        if (idx_q == KeyIdxW'(NumKeys - 1)) begin
          res_d   = blk_q ^ khi_q;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          blk_d          = perm_fwd(sub_fwd(blk_q ^ khi_q));
          {khi_d, klo_d} = sched_step(khi_q, klo_q, idx_q + KeyIdxW'(1));
          idx_d          = idx_q + KeyIdxW'(1);
        end
      end
      ST_DEC: begin
        rd_addr = idx_q - KeyIdxW'(1);
        if (idx_q == '0) begin
          res_d   = dec_n;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          blk_d = dec_n;
          idx_d = idx_q - KeyIdxW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // An accepted encrypt starts at round key zero
  a_enc_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_ENC)
      |=> (state_q == ST_ENC && idx_q == '0))
    else $error("encrypt did not start at round key zero");

  // The last encrypt cycle hands over a result and frees the sequencer
  a_enc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENC && idx_q == KeyIdxW'(NumKeys - 1))
      |=> (ovld_q && state_q == ST_IDLE))
    else $error("encrypt finished without a result");

  // No result may be waiting while an item is in work
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !ovld_q)
    else $error("result pending while sequencer busy");

  // A completed encryption leaves every round key valid
  a_store_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !$past(ovld_q) && $past(state_q) == ST_ENC) |-> (&vld_q))
    else $error("round-key store incomplete after encrypt");

endmodule
